// File: design/mrtu_pkg.sv
// Shared types and constants for the Modbus RTU request receiver.
`timescale 1ns / 1ps

package mrtu_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0]  ADDR_RESET = 8'd1;

   // Position of the byte that follows the address byte.
   typedef enum logic [2:0] {
      POS_FUNCTION = 3'd0,
      POS_START_HI = 3'd1,
      POS_START_LO = 3'd2,
      POS_COUNT_HI = 3'd3,
      POS_COUNT_LO = 3'd4,
      POS_CRC_LO   = 3'd5,
      POS_CRC_HI   = 3'd6
   } pos_type;

   typedef enum logic {
      EV_BYTE    = 1'b0,
      EV_TIMEOUT = 1'b1
   } event_type;

   typedef enum logic [2:0] {
      ST_IGNORED = 3'd0,
      ST_STORED  = 3'd1,
      ST_GOOD    = 3'd2,
      ST_BAD     = 3'd3,
      ST_ABORT   = 3'd4
   } status_type;

endpackage

// File: design/mrtu_crc_byte.sv
// One-byte CRC-16/MODBUS update, eight reflected shift-xor steps.
`timescale 1ns / 1ps

module mrtu_crc_byte (
   input  logic [15:0] crc_in,
   input  logic [7:0]  data_in,
   output logic [15:0] crc_out
);
   import mrtu_pkg::*;

   always_comb begin
      logic [15:0] c;
      c = crc_in ^ {8'd0, data_in};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      crc_out = c;
   end

endmodule

// File: design/modbus_rtu_request_receiver_top.sv
// Top level of the Modbus RTU request receiver with CRC-16 frame check.
`timescale 1ns / 1ps

// Each request is either a received UART byte or a receive timeout, and each
// request yields exactly one response in the cycle after it is accepted. While
// idle, a byte equal to the own address (csr port, reset value 1) opens a
// frame; seven more bytes follow: function, start register high/low, register
// count high/low, CRC low/high. The CRC-16/MODBUS runs over the address and
// the next five bytes, one byte per request, combinationally, so a request
// can be accepted on every clock, limited only by the response register
// draining. The seventh byte yields status good or bad with the decoded
// fields; a timeout during a frame yields status aborted. Ignored, stored
// and aborted responses carry zero fields. Write the own address only
// while no request is in flight.
module modbus_rtu_request_receiver_top (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_own_address,
   // requests
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_rx_byte,
   // responses
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_function_code,
   output logic [15:0] rsp_start_register,
   output logic [15:0] rsp_register_count
);
   import mrtu_pkg::*;

   // control state
   logic        receiving_ff, receiving_in;
   pos_type     pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  own_address_ff;
   logic        rsp_valid_ff, rsp_valid_in;

   // frame fields, valid only once written by the current frame
   logic [7:0]  function_ff, function_in;
   logic [15:0] start_ff, start_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;

   // response payload
   status_type  status_ff, status_in;
   logic [7:0]  out_function_ff, out_function_in;
   logic [15:0] out_start_ff, out_start_in;
   logic [15:0] out_count_ff, out_count_in;

   logic        req_accept;
   logic [15:0] crc_base;
   logic [15:0] crc_next;

   assign csr_ready  = 1'b1;
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // An address byte seeds the CRC from its init value.
   assign crc_base = receiving_ff ? crc_ff : CRC_INIT;

   mrtu_crc_byte u_crc (
      .crc_in  (crc_base),
      .data_in (req_rx_byte),
      .crc_out (crc_next)
   );

   always_comb begin
      receiving_in    = receiving_ff;
      pos_in          = pos_ff;
      crc_in          = crc_ff;
      function_in     = function_ff;
      start_in        = start_ff;
      count_in        = count_ff;
      crc_lo_in       = crc_lo_ff;
      status_in       = ST_IGNORED;
      out_function_in = 8'd0;
      out_start_in    = 16'd0;
      out_count_in    = 16'd0;

      if (req_opcode == EV_TIMEOUT) begin
         // drop a partial frame
         if (receiving_ff) begin
            receiving_in = 1'b0;
            pos_in       = POS_FUNCTION;
            crc_in       = CRC_INIT;
            status_in    = ST_ABORT;
         end
      end else if (!receiving_ff) begin
         // open a frame on our address, ignore anything else
         if (req_rx_byte == own_address_ff) begin
            receiving_in = 1'b1;
            pos_in       = POS_FUNCTION;
            crc_in       = crc_next;
            status_in    = ST_STORED;
         end
      end else begin
         status_in = ST_STORED;
         unique case (pos_ff)
            POS_FUNCTION: begin
               function_in = req_rx_byte;
               crc_in      = crc_next;
               pos_in      = POS_START_HI;
            end
            POS_START_HI: begin
               start_in[15:8] = req_rx_byte;
               crc_in         = crc_next;
               pos_in         = POS_START_LO;
            end
            POS_START_LO: begin
               start_in[7:0] = req_rx_byte;
               crc_in        = crc_next;
               pos_in        = POS_COUNT_HI;
            end
            POS_COUNT_HI: begin
               count_in[15:8] = req_rx_byte;
               crc_in         = crc_next;
               pos_in         = POS_COUNT_LO;
            end
            POS_COUNT_LO: begin
               count_in[7:0] = req_rx_byte;
               crc_in        = crc_next;
               pos_in        = POS_CRC_LO;
            end
            POS_CRC_LO: begin
               crc_lo_in = req_rx_byte;
               pos_in    = POS_CRC_HI;
            end
            default: begin
               // last byte: check CRC, report fields, return to idle
               status_in       = ({req_rx_byte, crc_lo_ff} == crc_ff) ? ST_GOOD : ST_BAD;
               out_function_in = function_ff;
               out_start_in    = start_ff;
               out_count_in    = count_ff;
               receiving_in    = 1'b0;
               pos_in          = POS_FUNCTION;
               crc_in          = CRC_INIT;
            end
         endcase
      end
   end

   // Hold the response until taken; a new one may load in the same cycle.
   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff   <= 1'b0;
         pos_ff         <= POS_FUNCTION;
         crc_ff         <= CRC_INIT;
         own_address_ff <= ADDR_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            own_address_ff <= csr_own_address;
         end
         if (req_accept) begin
            receiving_ff <= receiving_in;
            pos_ff       <= pos_in;
            crc_ff       <= crc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         function_ff     <= function_in;
         start_ff        <= start_in;
         count_ff        <= count_in;
         crc_lo_ff       <= crc_lo_in;
         status_ff       <= status_in;
         out_function_ff <= out_function_in;
         out_start_ff    <= out_start_in;
         out_count_ff    <= out_count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_function_code  = out_function_ff;
   assign rsp_start_register = out_start_ff;
   assign rsp_register_count = out_count_ff;

endmodule
